>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> src/dtip_pkg.sv
// ---------------------------------------------------------------------------
// dtip_pkg
// Constants, phase codes and character class helpers for the decimal
// text to int32 parser.
// ---------------------------------------------------------------------------
package dtip_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int PHASE_W = 3;
    localparam int PROD_W  = VALUE_W + 4;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]  char_t;

    localparam phase_t PH_EMPTY      = 3'd0;
    localparam phase_t PH_SPACE      = 3'd1;
    localparam phase_t PH_SIGN       = 3'd2;
    localparam phase_t PH_DIGITS     = 3'd3;
    localparam phase_t PH_BAD        = 3'd4;
    localparam phase_t PH_DIGITS_END = 3'd5;
    localparam phase_t PH_ZERO_END   = 3'd6;

    localparam value_t NA_CODE   = 32'h8000_0000;
    localparam value_t MAG_LIMIT = 32'h8000_0000;
    localparam value_t POS_MAX   = 32'h7FFF_FFFF;

    localparam char_t CH_NUL   = 8'd0;
    localparam char_t CH_PLUS  = 8'd43;
    localparam char_t CH_MINUS = 8'd45;
    localparam char_t CH_ZERO  = 8'd48;
    localparam char_t CH_NINE  = 8'd57;

    function automatic logic is_space(input char_t c);
        return c inside {[8'd9:8'd13], 8'd32};
    endfunction

    function automatic logic is_digit(input char_t c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

>>> src/decimal_text_to_int32_parser.sv
// ---------------------------------------------------------------------------
// decimal_text_to_int32_parser
// Parses decimal text, one byte per word, into a signed 32-bit integer.
// ---------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one character byte per word; a word
// with s_axis_tlast high ends the field (its tdata is ignored). Leading
// whitespace, an optional sign and decimal digits are taken; a zero byte
// ends the text. Output stream: one word per field, m_axis_tdata holds the
// value and m_axis_tuser flags NA, coded as 32'h8000_0000.
// Path: a field's end word is registered in the input register, then
// parsed into the result register, where the result becomes valid.
// Throughput: one input word per cycle while no end word waits for the
// result register; the multiply-by-ten and add on the accumulator is
// combinational, between the input and result registers.
// Reset clears the parse state and both stream stages. While the
// receiver stalls, character words keep flowing; an end word waits in
// the input register until the result register frees, and s_axis_tready
// drops only then.
// ---------------------------------------------------------------------------
module decimal_text_to_int32_parser
    import dtip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [31:0] value
    output logic         m_axis_tuser    // [0] is_na
);

    logic   in_valid_reg;
    logic   in_last_reg;
    char_t  in_char_reg;

    phase_t phase_reg,  phase_next;
    value_t mag_reg,    mag_next;
    logic   ovf_reg,    ovf_next;
    logic   neg_reg,    neg_next;

    logic   out_valid_reg;
    value_t out_value_reg;
    logic   out_na_reg;

    logic   fire;
    logic   take_in;
    logic   c_digit;
    logic   c_space;
    logic [PROD_W-1:0] prod;
    value_t mag_step;
    logic   ovf_step;
    value_t result;

    assign fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign take_in = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        c_digit  = is_digit(in_char_reg);
        c_space  = is_space(in_char_reg);
        prod     = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1)
                 + {{(PROD_W-4){1'b0}}, in_char_reg[3:0]};
        mag_step = mag_reg;
        ovf_step = ovf_reg;
        if (!ovf_reg)
        begin
            if (prod > {4'd0, MAG_LIMIT})
            begin
                ovf_step = 1'b1;
                mag_step = MAG_LIMIT;
            end
            else
            begin
                mag_step = prod[VALUE_W-1:0];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        case (phase_reg)
            PH_EMPTY, PH_SPACE:
            begin
                if (in_char_reg == CH_NUL)
                begin
                    phase_next = (phase_reg == PH_EMPTY) ? PH_ZERO_END : PH_BAD;
                end
                else if (c_space)
                begin
                    phase_next = PH_SPACE;
                end
                else if (in_char_reg == CH_PLUS || in_char_reg == CH_MINUS)
                begin
                    neg_next   = (in_char_reg == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else if (c_digit)
                begin
                    mag_next   = mag_step;
                    ovf_next   = ovf_step;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_SIGN:
            begin
                if (c_digit)
                begin
                    mag_next   = mag_step;
                    ovf_next   = ovf_step;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_DIGITS:
            begin
                if (in_char_reg == CH_NUL)
                begin
                    phase_next = PH_DIGITS_END;
                end
                else if (c_digit)
                begin
                    mag_next = mag_step;
                    ovf_next = ovf_step;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_BAD, PH_DIGITS_END, PH_ZERO_END:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_BAD;
            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_EMPTY, PH_ZERO_END:
            begin
                result = '0;
            end
            PH_DIGITS, PH_DIGITS_END:
            begin
                if (ovf_reg)
                begin
                    result = NA_CODE;
                end
                else if (neg_reg)
                begin
                    result = '0 - mag_reg;
                end
                else if (mag_reg > POS_MAX)
                begin
                    result = NA_CODE;
                end
                else
                begin
                    result = mag_reg;
                end
            end
            default:
            begin
                result = NA_CODE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_last_reg <= s_axis_tlast;
            in_char_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EMPTY;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (in_last_reg)
            begin
                phase_reg <= PH_EMPTY;
                mag_reg   <= '0;
                ovf_reg   <= 1'b0;
                neg_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                neg_reg   <= neg_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_value_reg <= result;
            out_na_reg    <= (result == NA_CODE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_na_reg;

endmodule

>>> src/dtip_checker.sv
// ---------------------------------------------------------------------------
// dtip_checker
// Port-level checks for the decimal text to int32 parser.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtip_checker
    import dtip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,   // [31:0] value
    input  logic         m_axis_tuser    // [0] is_na
);

    `ASSERT_CLK(a_out_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)),
        "result word changed while stalled")

    `ASSERT_CLK(a_na_flag, clk, rst_n,
        (m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == NA_CODE))),
        "NA flag disagrees with value")

    `ASSERT_CLK_ALWAYS(a_reset_idle, clk, (!rst_n |-> !m_axis_tvalid),
        "result valid during reset")

    `ASSERT_CLK(a_ready_free_out, clk, rst_n,
        (!m_axis_tvalid && $past(!m_axis_tvalid) |-> s_axis_tready),
        "input stalled with empty output")

endmodule

bind decimal_text_to_int32_parser dtip_checker u_dtip_checker (.*);
